// ----- sv/bfil_pkg.sv -----
// Package for the Bloom filter block: constants, payload structs, FSM states.
// Used by every module of the block; depends on nothing.
package bfil_pkg;
	localparam int FilterBits = 1024;
	localparam int AddrW = $clog2(FilterBits);
	localparam int SizeW = 11;
	localparam int CountW = 5;
	localparam int MaxHashes = 16;
	localparam int HashW = 64;
	localparam logic [HashW-1:0] DjbStart = 64'd5381;
	localparam logic [SizeW-1:0] SizeReset = 11'd1000;
	localparam logic [CountW-1:0] CountReset = 5'd4;
	localparam logic CfgFilterSize = 1'b0;
	localparam logic CfgHashCount = 1'b1;
	localparam logic ReqInsert = 1'b0;

	typedef struct packed {
		logic req_type;
		logic [7:0] key_byte;
		logic key_last;
	} in_item_t;

	typedef struct packed {
		logic found;
		logic was_insert;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MOD,
		ST_PROBE,
		ST_WAIT,
		ST_DONE
	} state_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic clr_wr;
		logic hash_en;
		logic mod_start;
		logic probe_first;
		logic probe_en;
		logic hash_reset;
	} cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic clr_done;
		logic mod_done;
		logic probes_done;
	} sts_t;
endpackage

// ----- sv/bfil_ctrl.sv -----
// Controller state machine for the Bloom filter block.
// Depends on bfil_pkg.
module bfil_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_last,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  bfil_pkg::sts_t sts,
	output bfil_pkg::cmd_t cmd
);
	bfil_pkg::state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfil_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			bfil_pkg::ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_done) begin
					state_d = bfil_pkg::ST_IDLE;
				end
			end
			bfil_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.hash_en = 1'b1;
					if (in_last) begin
						cmd.mod_start = 1'b1;
						state_d = bfil_pkg::ST_MOD;
					end
				end
			end
			bfil_pkg::ST_MOD: begin
				if (sts.mod_done) begin
					cmd.probe_first = 1'b1;
					state_d = bfil_pkg::ST_PROBE;
				end
			end
			bfil_pkg::ST_PROBE: begin
				if (sts.probes_done) begin
					state_d = bfil_pkg::ST_WAIT;
				end else begin
					cmd.probe_en = 1'b1;
				end
			end
			bfil_pkg::ST_WAIT: begin
				// let the last read-modify-write settle
				state_d = bfil_pkg::ST_DONE;
			end
			bfil_pkg::ST_DONE: begin
				out_valid = 1'b1;
				if (out_ready) begin
					cmd.hash_reset = 1'b1;
					state_d = bfil_pkg::ST_IDLE;
				end
			end
			default: state_d = bfil_pkg::ST_IDLE;
		endcase
	end
endmodule

// ----- sv/bfil_dp.sv -----
// Datapath for the Bloom filter block: hashes, serial modulo, probe address
// generation and the bit store. Depends on bfil_pkg.
module bfil_dp (
	input  logic clk,
	input  logic arst_n,
	input  bfil_pkg::in_item_t in_item,
	input  logic cfg_we,
	input  logic cfg_index,
	input  logic [bfil_pkg::SizeW-1:0] cfg_data,
	input  bfil_pkg::cmd_t cmd,
	output bfil_pkg::sts_t sts,
	output bfil_pkg::out_item_t out_item
);
	localparam int AW = bfil_pkg::AddrW;
	localparam int SW = bfil_pkg::SizeW;
	localparam int HW = bfil_pkg::HashW;
	localparam int CW = bfil_pkg::CountW;
	localparam int BitCntW = $clog2(HW + 1);

	logic [SW-1:0] size_q;
	logic [CW-1:0] count_q;
	logic [HW-1:0] djb_q, kr_q;
	logic [SW-1:0] used_size;
	logic [CW-1:0] used_count;
	logic [HW-1:0] djb_sh_q, kr_sh_q;
	logic [SW:0] rem1_q, rem2_q;
	logic [BitCntW-1:0] bit_cnt_q;
	logic mod_busy_q;
	logic [SW:0] r1_try, r2_try;
	logic [AW:0] pos_q, step_q;
	logic [CW-1:0] done_cnt_q;
	logic [AW:0] next_pos;
	logic [AW:0] size_ext;
	logic req_q;
	logic all_q;
	logic mem [bfil_pkg::FilterBits];
	logic [AW:0] clr_cnt_q;
	logic rd_pend_s1;
	logic [AW-1:0] rd_addr_s1;
	logic rd_bit;
	logic [AW-1:0] wr_addr;
	logic wr_en, wr_val;

	// Clamp configuration to the usable range.
	always_comb begin
		used_size = size_q;
		if (size_q == '0) begin
			used_size = SW'(1);
		end else if (size_q > SW'(bfil_pkg::FilterBits)) begin
			used_size = SW'(bfil_pkg::FilterBits);
		end
		used_count = count_q;
		if (count_q > CW'(bfil_pkg::MaxHashes)) begin
			used_count = CW'(bfil_pkg::MaxHashes);
		end
	end
	assign size_ext = (AW + 1)'(used_size);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= bfil_pkg::SizeReset;
			count_q <= bfil_pkg::CountReset;
		end else if (cfg_we) begin
			if (cfg_index == bfil_pkg::CfgFilterSize) begin
				size_q <= cfg_data;
			end else begin
				count_q <= cfg_data[CW-1:0];
			end
		end
	end

	// Running hashes, one byte per item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			djb_q <= bfil_pkg::DjbStart;
			kr_q <= '0;
		end else if (cmd.hash_reset) begin
			djb_q <= bfil_pkg::DjbStart;
			kr_q <= '0;
		end else if (cmd.hash_en && in_item.key_byte != 8'd0) begin
			djb_q <= (djb_q << 5) + djb_q + HW'(in_item.key_byte);
			kr_q <= (kr_q << 5) - (kr_q << 1) + kr_q + HW'(in_item.key_byte);
		end
	end

	// Bit-serial restoring modulo of both hashes, one bit a cycle.
	assign r1_try = {rem1_q[SW-1:0], djb_sh_q[HW-1]};
	assign r2_try = {rem2_q[SW-1:0], kr_sh_q[HW-1]};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_busy_q <= 1'b0;
			bit_cnt_q <= '0;
		end else if (cmd.mod_start) begin
			mod_busy_q <= 1'b1;
			bit_cnt_q <= BitCntW'(HW);
		end else if (mod_busy_q) begin
			bit_cnt_q <= bit_cnt_q - 1'b1;
			if (bit_cnt_q == BitCntW'(1)) begin
				mod_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mod_start) begin
			// the last byte updates the hash in the same edge; fold it in here
			if (in_item.key_byte != 8'd0) begin
				djb_sh_q <= (djb_q << 5) + djb_q + HW'(in_item.key_byte);
				kr_sh_q <= (kr_q << 5) - (kr_q << 1) + kr_q + HW'(in_item.key_byte);
			end else begin
				djb_sh_q <= djb_q;
				kr_sh_q <= kr_q;
			end
			rem1_q <= '0;
			rem2_q <= '0;
			req_q <= in_item.req_type;
		end else if (mod_busy_q) begin
			djb_sh_q <= djb_sh_q << 1;
			kr_sh_q <= kr_sh_q << 1;
			rem1_q <= (r1_try >= (SW + 1)'(used_size)) ? r1_try - (SW + 1)'(used_size)
				: r1_try;
			rem2_q <= (r2_try >= (SW + 1)'(used_size)) ? r2_try - (SW + 1)'(used_size)
				: r2_try;
		end
	end
	assign sts.mod_done = mod_busy_q == 1'b0 && bit_cnt_q == '0;

	// Probe address sequence: h1, h2, h1+h2, h1+2*h2, ...
	always_comb begin
		next_pos = pos_q + step_q;
		if (next_pos >= size_ext) begin
			next_pos = next_pos - size_ext;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_cnt_q <= '0;
			all_q <= 1'b1;
			rd_pend_s1 <= 1'b0;
		end else begin
			rd_pend_s1 <= 1'b0;
			if (cmd.probe_first) begin
				done_cnt_q <= '0;
				all_q <= 1'b1;
			end else if (cmd.probe_en) begin
				done_cnt_q <= done_cnt_q + 1'b1;
				rd_pend_s1 <= 1'b1;
			end
			if (rd_pend_s1 && !rd_bit) begin
				all_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.probe_first) begin
			pos_q <= rem1_q[AW:0];
			step_q <= rem2_q[AW:0];
		end else if (cmd.probe_en) begin
			rd_addr_s1 <= pos_q[AW-1:0];
			if (done_cnt_q == '0) begin
				pos_q <= step_q;
			end else if (done_cnt_q == CW'(1)) begin
				pos_q <= (rem1_q[AW:0] + step_q >= size_ext)
					? rem1_q[AW:0] + step_q - size_ext : rem1_q[AW:0] + step_q;
			end else begin
				pos_q <= next_pos;
			end
		end
	end
	assign sts.probes_done = done_cnt_q == used_count;

	// Clearing sweep after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr_wr && !clr_cnt_q[AW]) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end
	assign sts.clr_done = clr_cnt_q[AW];

	// Bit store: one write port, one registered read port.
	assign wr_en = cmd.clr_wr || (rd_pend_s1 && req_q == bfil_pkg::ReqInsert);
	assign wr_addr = cmd.clr_wr ? clr_cnt_q[AW-1:0] : rd_addr_s1;
	assign wr_val = !cmd.clr_wr;
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_val;
		end
	end
	always_ff @(posedge clk) begin
		rd_bit <= mem[pos_q[AW-1:0]];
	end

	assign out_item.found = req_q != bfil_pkg::ReqInsert && all_q;
	assign out_item.was_insert = req_q == bfil_pkg::ReqInsert;
endmodule

// ----- sv/bloom_filter_insert_lookup.sv -----
// Top level of the Bloom filter block: joins controller and datapath.
// Depends on bfil_pkg, bfil_ctrl, bfil_dp.
//
// Channel  Dir  Handshake           Payload
// in       in   in_valid/in_ready   bfil_pkg::in_item_t
// out      out  out_valid/out_ready bfil_pkg::out_item_t
// cfg      in   cfg_we              cfg_index, cfg_data
//
// A non-final key byte only updates the running hashes. A final byte is taken
// and then runs the bit-serial modulo of both hashes, the probes (one
// bit-store access each), a settle state and the result. After reset a
// clearing sweep runs before the first item is taken. A held result blocks
// new items until taken.
module bloom_filter_insert_lookup (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  bfil_pkg::in_item_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output bfil_pkg::out_item_t out_data,
	input  logic cfg_we,
	input  logic cfg_index,
	input  logic [bfil_pkg::SizeW-1:0] cfg_data
);
	bfil_pkg::cmd_t cmd;
	bfil_pkg::sts_t sts;

	bfil_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_last(in_data.key_last),
		.in_ready(in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sts(sts),
		.cmd(cmd)
	);

	bfil_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.in_item(in_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cmd(cmd),
		.sts(sts),
		.out_item(out_data)
	);
endmodule

// ----- tb/bfil_checker.sv -----
// Checker for the Bloom filter block: watches the input, output and config ports,
// predicts each result and compares. Depends on bfil_pkg.
`timescale 1ns / 1ps

module bfil_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_ready,
	input  bfil_pkg::in_item_t in_data,
	input  logic out_valid,
	input  logic out_ready,
	input  bfil_pkg::out_item_t out_data,
	input  logic cfg_we,
	input  logic cfg_index,
	input  logic [bfil_pkg::SizeW-1:0] cfg_data,
	output int fails,
	output int pending,
	output int hits
);
	bit fbits [bfil_pkg::FilterBits];
	bit [bfil_pkg::HashW-1:0] djb_acc, kr_acc;
	bit [bfil_pkg::SizeW-1:0] size_reg;
	bit [bfil_pkg::CountW-1:0] count_reg;
	bfil_pkg::out_item_t answer_q [$];

	assign pending = answer_q.size();

	task automatic report(input string what, input bfil_pkg::out_item_t got,
		input bfil_pkg::out_item_t want);
		fails++;
		$display("%0t mismatch %s: got found=%0b was_insert=%0b, want found=%0b was_insert=%0b",
			$realtime, what, got.found, got.was_insert, want.found, want.was_insert);
	endtask

	// Hash the byte; on the last byte probe the filter and form the answer.
	function automatic bfil_pkg::out_item_t filter_step(input bfil_pkg::in_item_t it,
		output bit done);
		int unsigned sz, k, h1, h2, pos;
		bit all_set, ins;
		bfil_pkg::out_item_t res;
		all_set = 1'b1;
		res = '0;
		done = 1'b0;
		if (it.key_byte != 8'd0) begin
			djb_acc = (djb_acc << 5) + djb_acc + it.key_byte;
			kr_acc = it.key_byte + kr_acc * 64'd31;
		end
		if (it.key_last) begin
			sz = (size_reg == 0) ? 1 : size_reg;
			if (sz > bfil_pkg::FilterBits) sz = bfil_pkg::FilterBits;
			k = (count_reg > bfil_pkg::MaxHashes) ? bfil_pkg::MaxHashes : count_reg;
			h1 = 32'(djb_acc % sz);
			h2 = 32'(kr_acc % sz);
			ins = (it.req_type == bfil_pkg::ReqInsert);
			for (int i = 0; i < k; i++) begin
				if (i == 0) pos = h1;
				else if (i == 1) pos = h2;
				else pos = (h1 + (i - 1) * h2) % sz;
				if (ins) fbits[pos] = 1'b1;
				all_set &= fbits[pos];
			end
			djb_acc = bfil_pkg::DjbStart;
			kr_acc = '0;
			res.found = !ins && all_set;
			res.was_insert = ins;
			done = 1'b1;
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		bfil_pkg::out_item_t res, want;
		bit done;
		if (!arst_n) begin
			foreach (fbits[i]) fbits[i] = 1'b0;
			djb_acc = bfil_pkg::DjbStart;
			kr_acc = '0;
			size_reg = bfil_pkg::SizeReset;
			count_reg = bfil_pkg::CountReset;
			answer_q.delete();
			fails = 0;
			hits = 0;
		end else begin
			// compare the result first, then account for the new item
			if (out_valid && out_ready) begin
				if (answer_q.size() == 0) begin
					report("unexpected result", out_data, '0);
				end else begin
					want = answer_q.pop_front();
					if (out_data.found !== want.found)
						report("found", out_data, want);
					else if (out_data.was_insert !== want.was_insert)
						report("was_insert", out_data, want);
				end
			end
			if (in_valid && in_ready) begin
				res = filter_step(in_data, done);
				if (done) begin
					answer_q.push_back(res);
					if (res.found) hits++;
				end
			end
			if (cfg_we) begin
				if (cfg_index == bfil_pkg::CfgFilterSize) size_reg = cfg_data;
				else count_reg = cfg_data[bfil_pkg::CountW-1:0];
			end
		end
	end
endmodule

// ----- tb/testbench.sv -----
// Top of the Bloom filter testbench: clock, reset, key stimulus, config phases, verdict.
// Depends on bfil_pkg, bloom_filter_insert_lookup and bfil_checker.
`timescale 1ns / 1ps

module testbench;
	localparam int Limit = 600000;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	bfil_pkg::in_item_t in_data;
	bfil_pkg::out_item_t out_data;
	logic cfg_we, cfg_index;
	logic [bfil_pkg::SizeW-1:0] cfg_data;
	int fails, pending, hits;
	int tx_idle, rx_idle, cycles, items, keys;
	bit [47:0] stored_key [$];
	int stored_len [$];

	bloom_filter_insert_lookup u_top (.*);
	bfil_checker u_chk (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Stop the run if it hangs.
	always @(posedge clk) begin
		cycles++;
		if (cycles > Limit) begin
			$display("timeout after %0d cycles", cycles);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Stall the output at the rate of the current phase.
	always @(negedge clk) out_ready <= ($urandom_range(99) >= rx_idle);

	// Offer one item and hold it until taken.
	task automatic send_item(input logic req, input logic [7:0] b, input logic last);
		if ($urandom_range(99) < tx_idle) begin
			in_valid = 1'b0;
			repeat ($urandom_range(3, 1)) @(negedge clk);
		end
		in_valid = 1'b1;
		in_data = '{req_type: req, key_byte: b, key_last: last};
		do @(posedge clk); while (!in_ready);
		items++;
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// Send a key of len bytes, low byte first; req_type is noise on non-final bytes.
	task automatic send_key(input logic req, input bit [47:0] kb, input int len);
		for (int i = 0; i < len; i++)
			send_item((i == len - 1) ? req : logic'($urandom_range(1)), kb[8*i +: 8],
				i == len - 1);
		keys++;
	endtask

	// Let every result arrive, then let the final probes settle.
	task automatic drain();
		while (pending != 0) @(negedge clk);
		repeat (120) @(negedge clk);
	endtask

	task automatic write_cfg(input logic idx, input logic [bfil_pkg::SizeW-1:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Random keys: mostly inserts and lookups of known keys, some fresh ones.
	task automatic random_keys(input int n);
		bit [47:0] kb;
		int len, pick, sel;
		for (int j = 0; j < n; j++) begin
			pick = $urandom_range(99);
			if (pick < 40 && stored_key.size() > 0) begin
				sel = $urandom_range(stored_key.size() - 1);
				send_key(1'b1, stored_key[sel], stored_len[sel]);
			end else begin
				len = $urandom_range(6, 1);
				kb = 48'({$urandom, $urandom});
				for (int i = 0; i < 6; i++)
					if ($urandom_range(9) == 0) kb[8*i +: 8] = 8'h00;
				if (pick < 75) begin
					send_key(1'b0, kb, len);
					stored_key.push_back(kb);
					stored_len.push_back(len);
					if (stored_key.size() > 40) begin
						void'(stored_key.pop_front());
						void'(stored_len.pop_front());
					end
				end else begin
					send_key(1'b1, kb, len);
				end
			end
		end
	endtask

	initial begin
		logic [bfil_pkg::SizeW-1:0] sizes [9] = '{11'd1000, 11'd1, 11'd0, 11'd2047,
			11'd1024, 11'd7, 11'd64, 11'd513, 11'd1000};
		logic [bfil_pkg::SizeW-1:0] counts [9] = '{11'd4, 11'd0, 11'd1, 11'd31, 11'd16,
			11'd2, 11'd17, 11'd3, 11'h7E5};
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = bfil_pkg::CfgFilterSize;
		cfg_data = '0;
		tx_idle = 0;
		rx_idle = 0;
		arst_n = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// Directed: extremes, empty key, zero-byte keys, reset config.
		send_key(1'b1, 48'h0000_0000_00FF, 1);
		send_key(1'b0, 48'h0000_0000_00FF, 1);
		send_key(1'b1, 48'h0000_0000_00FF, 1);
		send_key(1'b1, 48'h0, 1);
		send_key(1'b0, 48'h0, 3);
		send_key(1'b1, 48'h0, 1);
		send_key(1'b0, 48'h0000_00FF_0080, 3);
		send_key(1'b1, 48'h0000_0000_FF80, 2);
		send_key(1'b1, 48'h0000_0001_0000, 3);
		drain();

		// Phases: idle pattern and config vary together.
		for (int ph = 0; ph < 9; ph++) begin
			tx_idle = (ph < 3) ? 26 : (ph < 6) ? 79 : 0;
			rx_idle = (ph < 3) ? 79 : (ph < 6) ? 26 : 0;
			write_cfg(bfil_pkg::CfgFilterSize, sizes[ph]);
			write_cfg(bfil_pkg::CfgHashCount, counts[ph]);
			random_keys(45);
			drain();
		end

		$display("covered %0d items in %0d keys over 9 config settings", items, keys);
		$display("lookups reported found %0d times; %0d mismatches", hits, fails);
		if (fails == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

// ----- files.f -----
sv/bfil_pkg.sv
sv/bfil_ctrl.sv
sv/bfil_dp.sv
sv/bloom_filter_insert_lookup.sv
tb/bfil_checker.sv
tb/testbench.sv
